// ===== src/adss_pkg.sv =====
// Shared types, constants and helper functions of the advertising data service scanner.
package adss_pkg;

    // Default longest local name that can be kept.
    localparam int NAME_MAX_DEF = 32;

    // Bytes in one 128-bit service UUID.
    localparam int UUID_BYTES = 16;

    // Widths of the fixed-size fields that travel between the parser and the name store.
    localparam int IDX_W_MAX = 6;
    localparam int LEN_W_MAX = 7;

    // AD structure type codes.
    localparam logic [7:0] AD_UUID128_PART  = 8'h06;
    localparam logic [7:0] AD_UUID128_FULL  = 8'h07;
    localparam logic [7:0] AD_NAME_SHORT    = 8'h08;
    localparam logic [7:0] AD_NAME_COMPLETE = 8'h09;

    // Service kinds.
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_FIRST = 2'd1;
    localparam logic [1:0] KIND_SECOND = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_NUS_LOW  = 3'd0;
    localparam logic [2:0] CFG_NUS_HIGH = 3'd1;
    localparam logic [2:0] CFG_SPS_LOW  = 3'd2;
    localparam logic [2:0] CFG_SPS_HIGH = 3'd3;

    typedef enum logic [1:0] {
        PH_LEN  = 2'd0,
        PH_TYPE = 2'd1,
        PH_DATA = 2'd2,
        PH_DONE = 2'd3
    } adss_phase_t;

    // Write of one name character into the name store.
    typedef struct packed {
        logic                 en;
        logic                 bank;
        logic [IDX_W_MAX-1:0] idx;
        logic [7:0]           data;
    } adss_wr_t;

    // Start of a name read-out, with the values that every result item carries.
    typedef struct packed {
        logic                 go;
        logic                 bank;
        logic [LEN_W_MAX-1:0] len;
        logic                 found;
        logic [1:0]           kind;
    } adss_dump_t;

    // Status of the read-out engine.
    typedef struct packed {
        logic busy;
        logic bank;
    } adss_stat_t;

    function automatic logic is_name_type(input logic [7:0] t);
        return (t == AD_NAME_COMPLETE) || (t == AD_NAME_SHORT);
    endfunction

    function automatic logic is_uuid_type(input logic [7:0] t);
        return (t == AD_UUID128_PART) || (t == AD_UUID128_FULL);
    endfunction

    // On-air byte pos of a UUID held as two 64-bit halves, byte 0 lowest.
    function automatic logic [7:0] uuid_byte(input logic [63:0] lo, input logic [63:0] hi,
                                             input logic [3:0] pos);
        logic [63:0] w;
        w = pos[3] ? hi : lo;
        return w[{pos[2:0], 3'b000} +: 8];
    endfunction

endpackage

// ===== src/adss_name_store.sv =====
// Name store memory with the read-out engine and a two-entry output queue.
module adss_name_store #(
    parameter int NAME_MAX = adss_pkg::NAME_MAX_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  adss_pkg::adss_wr_t  wr,
    input  adss_pkg::adss_dump_t start,
    output adss_pkg::adss_stat_t stat,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_name_byte,
    output logic [4:0]          m_name_index,
    output logic [5:0]          m_name_length,
    output logic                m_name_found,
    output logic [1:0]          m_service_kind,
    output logic                m_run_end
);

    localparam int DEPTH = 2 * NAME_MAX;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
    localparam int LW    = $clog2(NAME_MAX + 2);

    logic [7:0] mem [DEPTH];

    // Snapshot of the read-out.
    logic          bank_reg;
    logic [LW-1:0] len_reg;
    logic          found_reg;
    logic [1:0]    kind_reg;
    logic [IW-1:0] last_idx_reg;
    logic [IW-1:0] k_reg;
    logic          issuing_reg;

    // Read in flight.
    logic          infl_reg;
    logic [IW-1:0] infl_idx_reg;
    logic          infl_last_reg;
    logic [7:0]    rdata_reg;

    // Output queue: entry 0 is the head.
    logic [1:0]    occ_reg;
    logic [7:0]    q0_byte_reg, q1_byte_reg;
    logic [IW-1:0] q0_idx_reg, q1_idx_reg;
    logic          q0_last_reg, q1_last_reg;

    logic [AW-1:0] waddr, raddr;
    logic [LW-1:0] start_len;
    logic [IW-1:0] start_last;
    logic [1:0]    used;
    logic          pop, push, issue;
    logic [7:0]    push_byte;

    assign waddr = wr.bank ? AW'(NAME_MAX) + AW'(wr.idx) : AW'(wr.idx);
    assign raddr = bank_reg ? AW'(NAME_MAX) + AW'(k_reg) : AW'(k_reg);

    assign start_len  = LW'(start.len);
    assign start_last = (start_len == '0) ? '0 : IW'(start_len - LW'(1));

    assign pop   = m_valid && m_ready;
    assign push  = infl_reg;
    assign used  = occ_reg + {1'b0, infl_reg};
    assign issue = issuing_reg && ((used < 2'd2) || (used == 2'd2 && pop));
    assign push_byte = (len_reg == '0) ? 8'd0 : rdata_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[waddr] <= wr.data;
        end
        if (issue) begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issuing_reg <= 1'b0;
            infl_reg    <= 1'b0;
            occ_reg     <= 2'd0;
            bank_reg    <= 1'b0;
            k_reg       <= '0;
        end else begin
            if (start.go) begin
                issuing_reg  <= 1'b1;
                k_reg        <= '0;
                bank_reg     <= start.bank;
                len_reg      <= start_len;
                found_reg    <= start.found;
                kind_reg     <= start.kind;
                last_idx_reg <= start_last;
            end else if (issue) begin
                k_reg <= k_reg + IW'(1);
                if (k_reg == last_idx_reg) begin
                    issuing_reg <= 1'b0;
                end
            end

            infl_reg <= issue;
            if (issue) begin
                infl_idx_reg  <= k_reg;
                infl_last_reg <= (k_reg == last_idx_reg);
            end

            case ({push, pop})
                2'b10: begin
                    occ_reg <= occ_reg + 2'd1;
                    if (occ_reg == 2'd0) begin
                        q0_byte_reg <= push_byte;
                        q0_idx_reg  <= infl_idx_reg;
                        q0_last_reg <= infl_last_reg;
                    end else begin
                        q1_byte_reg <= push_byte;
                        q1_idx_reg  <= infl_idx_reg;
                        q1_last_reg <= infl_last_reg;
                    end
                end
                2'b01: begin
                    occ_reg     <= occ_reg - 2'd1;
                    q0_byte_reg <= q1_byte_reg;
                    q0_idx_reg  <= q1_idx_reg;
                    q0_last_reg <= q1_last_reg;
                end
                2'b11: begin
                    if (occ_reg == 2'd1) begin
                        q0_byte_reg <= push_byte;
                        q0_idx_reg  <= infl_idx_reg;
                        q0_last_reg <= infl_last_reg;
                    end else begin
                        q0_byte_reg <= q1_byte_reg;
                        q0_idx_reg  <= q1_idx_reg;
                        q0_last_reg <= q1_last_reg;
                        q1_byte_reg <= push_byte;
                        q1_idx_reg  <= infl_idx_reg;
                        q1_last_reg <= infl_last_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign stat.busy = issuing_reg || infl_reg || (occ_reg != 2'd0);
    assign stat.bank = bank_reg;

    assign m_valid        = (occ_reg != 2'd0);
    assign m_name_byte    = q0_byte_reg;
    assign m_name_index   = 5'(q0_idx_reg);
    assign m_name_length  = 6'(len_reg);
    assign m_name_found   = found_reg;
    assign m_service_kind = kind_reg;
    assign m_run_end      = q0_last_reg;

`ifndef ASSERT_OFF
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= 2'd2)
        else $error("output queue overfilled");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && occ_reg == 2'd2) |-> pop)
        else $error("read data arrived with the output queue full");

    a_go_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start.go |-> !stat.busy)
        else $error("read-out started while the previous one is running");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (issue && k_reg == last_idx_reg && !start.go) |=> !issuing_reg)
        else $error("read-out did not stop after its last character");
`endif

endmodule

// ===== src/adv_data_service_scanner_top.sv =====
// Top level of the advertising data service scanner: parser, configuration and name store.
//
// The scanner takes one advertising data byte per item and walks its length-type-value
// structures at one item per clock. Local names (types 0x08 and 0x09) of 1 to NAME_MAX
// characters are written into one bank of a two-bank name memory and become the kept name
// when the structure completes; 128-bit UUID lists (types 0x06 and 0x07) are compared chunk
// by chunk against the two configured service UUIDs. On an item that carries final_byte the
// kept name is read back from the memory at one character per cycle, unless m_ready holds
// off the output queue, and delivered as one result item per character (a single item with a
// zero character when no name was kept), the last one flagged by run_end; the parse state
// then starts afresh. The pace of a read-out is set by the single read port of the name
// memory and its registered read. Input items keep flowing during a read-out, with two
// exceptions that hold off s_ready until the read-out has drained: another final byte, and
// a name character that would land in the bank being read out. Configuration writes are
// taken in any cycle and should only be issued while the scanner is idle. There is no
// clearing pass after reset.
module adv_data_service_scanner_top #(
    parameter int NAME_MAX = adss_pkg::NAME_MAX_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_ad_byte,
    input  logic        s_final_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_name_byte,
    output logic [4:0]  m_name_index,
    output logic [5:0]  m_name_length,
    output logic        m_name_found,
    output logic [1:0]  m_service_kind,
    output logic        m_run_end
);

    localparam int LW = $clog2(NAME_MAX + 2);

    // Service UUID registers.
    logic [63:0] nus_low_reg, nus_high_reg, sps_low_reg, sps_high_reg;

    // Parse state.
    adss_pkg::adss_phase_t phase_reg, phase_next;
    logic [7:0]    bytes_left_reg, bytes_left_next;
    logic [7:0]    struct_type_reg, struct_type_next;
    logic [3:0]    chunk_offset_reg, chunk_offset_next;
    logic [1:0]    match_reg, match_next;
    logic [1:0]    pend_kind_reg, pend_kind_next;
    logic [1:0]    kept_kind_reg, kept_kind_next;
    logic          sel_reg, sel_next;
    logic [LW-1:0] pend_len_reg, pend_len_next;
    logic [LW-1:0] kept_len_reg, kept_len_next;
    logic          found_reg, found_next;

    adss_pkg::adss_wr_t   wr;
    adss_pkg::adss_dump_t start;
    adss_pkg::adss_stat_t stat;

    logic accept;
    logic name_wr_pending;

    // A name character is stored only while fewer than NAME_MAX have been taken.
    assign name_wr_pending = (phase_reg == adss_pkg::PH_DATA)
                          && adss_pkg::is_name_type(struct_type_reg)
                          && (pend_len_reg < LW'(NAME_MAX));

    assign s_ready = !(stat.busy && (s_final_byte || (name_wr_pending && (!sel_reg == stat.bank))));
    assign accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nus_low_reg  <= '0;
            nus_high_reg <= '0;
            sps_low_reg  <= '0;
            sps_high_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                adss_pkg::CFG_NUS_LOW:  nus_low_reg  <= cfg_data;
                adss_pkg::CFG_NUS_HIGH: nus_high_reg <= cfg_data;
                adss_pkg::CFG_SPS_LOW:  sps_low_reg  <= cfg_data;
                adss_pkg::CFG_SPS_HIGH: sps_high_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // One parse step for the accepted byte, followed by the commit of a completed structure
    // and, on a final byte, the start of the read-out and a return to the initial state.
    always_comb begin
        logic       finish;
        logic [1:0] m;

        phase_next        = phase_reg;
        bytes_left_next   = bytes_left_reg;
        struct_type_next  = struct_type_reg;
        chunk_offset_next = chunk_offset_reg;
        match_next        = match_reg;
        pend_kind_next    = pend_kind_reg;
        kept_kind_next    = kept_kind_reg;
        sel_next          = sel_reg;
        pend_len_next     = pend_len_reg;
        kept_len_next     = kept_len_reg;
        found_next        = found_reg;
        finish            = 1'b0;
        m                 = match_reg;

        wr.en   = 1'b0;
        wr.bank = !sel_reg;
        wr.idx  = adss_pkg::IDX_W_MAX'(pend_len_reg);
        wr.data = s_ad_byte;

        start.go    = 1'b0;
        start.bank  = 1'b0;
        start.len   = '0;
        start.found = 1'b0;
        start.kind  = adss_pkg::KIND_NONE;

        if (accept) begin
            case (phase_reg)
                adss_pkg::PH_LEN: begin
                    if (s_ad_byte == 8'd0) begin
                        phase_next = adss_pkg::PH_DONE;
                    end else begin
                        bytes_left_next = s_ad_byte;
                        phase_next      = adss_pkg::PH_TYPE;
                    end
                end
                adss_pkg::PH_TYPE: begin
                    struct_type_next  = s_ad_byte;
                    bytes_left_next   = bytes_left_reg - 8'd1;
                    pend_len_next     = '0;
                    pend_kind_next    = adss_pkg::KIND_NONE;
                    chunk_offset_next = 4'd0;
                    match_next        = 2'b11;
                    // A structure with a type byte only carries nothing to commit.
                    if (bytes_left_next == 8'd0) begin
                        phase_next = adss_pkg::PH_LEN;
                    end else begin
                        phase_next = adss_pkg::PH_DATA;
                    end
                end
                adss_pkg::PH_DATA: begin
                    if (adss_pkg::is_name_type(struct_type_reg)) begin
                        wr.en = name_wr_pending;
                        if (pend_len_reg <= LW'(NAME_MAX)) begin
                            pend_len_next = pend_len_reg + LW'(1);
                        end
                    end else if (adss_pkg::is_uuid_type(struct_type_reg)) begin
                        if (s_ad_byte != adss_pkg::uuid_byte(nus_low_reg, nus_high_reg,
                                                             chunk_offset_reg)) begin
                            m[0] = 1'b0;
                        end
                        if (s_ad_byte != adss_pkg::uuid_byte(sps_low_reg, sps_high_reg,
                                                             chunk_offset_reg)) begin
                            m[1] = 1'b0;
                        end
                        if (chunk_offset_reg == 4'(adss_pkg::UUID_BYTES - 1)) begin
                            // The first service wins when both match.
                            if (m[0]) begin
                                pend_kind_next = adss_pkg::KIND_FIRST;
                            end else if (m[1]) begin
                                pend_kind_next = adss_pkg::KIND_SECOND;
                            end
                            match_next        = 2'b11;
                            chunk_offset_next = 4'd0;
                        end else begin
                            match_next        = m;
                            chunk_offset_next = chunk_offset_reg + 4'd1;
                        end
                    end
                    bytes_left_next = bytes_left_reg - 8'd1;
                    finish          = (bytes_left_next == 8'd0);
                end
                default: begin
                end
            endcase

            if (finish) begin
                phase_next = adss_pkg::PH_LEN;
                if (adss_pkg::is_name_type(struct_type_reg)) begin
                    if (pend_len_next != '0 && pend_len_next <= LW'(NAME_MAX)) begin
                        sel_next      = !sel_reg;
                        kept_len_next = pend_len_next;
                        found_next    = 1'b1;
                    end
                end else if (adss_pkg::is_uuid_type(struct_type_reg)) begin
                    if (pend_kind_next != adss_pkg::KIND_NONE) begin
                        kept_kind_next = pend_kind_next;
                    end
                end
            end

            if (s_final_byte) begin
                start.go    = 1'b1;
                start.bank  = sel_next;
                start.len   = adss_pkg::LEN_W_MAX'(kept_len_next);
                start.found = found_next;
                start.kind  = kept_kind_next;

                phase_next        = adss_pkg::PH_LEN;
                bytes_left_next   = 8'd0;
                struct_type_next  = 8'd0;
                chunk_offset_next = 4'd0;
                match_next        = 2'b11;
                pend_kind_next    = adss_pkg::KIND_NONE;
                pend_len_next     = '0;
                kept_kind_next    = adss_pkg::KIND_NONE;
                kept_len_next     = '0;
                found_next        = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= adss_pkg::PH_LEN;
            bytes_left_reg   <= 8'd0;
            struct_type_reg  <= 8'd0;
            chunk_offset_reg <= 4'd0;
            match_reg        <= 2'b11;
            pend_kind_reg    <= adss_pkg::KIND_NONE;
            kept_kind_reg    <= adss_pkg::KIND_NONE;
            sel_reg          <= 1'b0;
            pend_len_reg     <= '0;
            kept_len_reg     <= '0;
            found_reg        <= 1'b0;
        end else begin
            phase_reg        <= phase_next;
            bytes_left_reg   <= bytes_left_next;
            struct_type_reg  <= struct_type_next;
            chunk_offset_reg <= chunk_offset_next;
            match_reg        <= match_next;
            pend_kind_reg    <= pend_kind_next;
            kept_kind_reg    <= kept_kind_next;
            sel_reg          <= sel_next;
            pend_len_reg     <= pend_len_next;
            kept_len_reg     <= kept_len_next;
            found_reg        <= found_next;
        end
    end

    adss_name_store #(
        .NAME_MAX (NAME_MAX)
    ) u_store (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .wr             (wr),
        .start          (start),
        .stat           (stat),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_name_byte    (m_name_byte),
        .m_name_index   (m_name_index),
        .m_name_length  (m_name_length),
        .m_name_found   (m_name_found),
        .m_service_kind (m_service_kind),
        .m_run_end      (m_run_end)
    );

`ifndef ASSERT_OFF
    a_no_write_into_readout: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr.en && stat.busy) |-> (wr.bank != stat.bank))
        else $error("name character written into the bank being read out");

    a_kept_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        kept_len_reg <= LW'(NAME_MAX))
        else $error("kept name longer than the name buffer");
`endif

endmodule
